>>> src/cv_pot_to_synth_params_defines.svh
// ----------------------------------------------------------------------------
// CV/pot to synth parameters: assertion macros
// Assertion wrappers for the block; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CV_POT_TO_SYNTH_PARAMS_DEFINES_SVH
`define CV_POT_TO_SYNTH_PARAMS_DEFINES_SVH

`ifndef SYNTH
// Clocked property, disabled while the active-low reset is asserted.
`define CVP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("cvpot assertion failed");
// Clocked property that is checked during reset as well.
`define CVP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("cvpot assertion failed");
`else
`define CVP_ASSERT(lbl, clk, rst_n, prop)
`define CVP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/cvpot_pkg.sv
// ----------------------------------------------------------------------------
// CV/pot to synth parameters: package
// Register indexes, pitch range modes, reset values and fixed constants.
// ----------------------------------------------------------------------------
package cvpot_pkg;

    typedef enum logic [1:0] {
        PM_TRACK = 2'd0,
        PM_FREE  = 2'd1,
        PM_FIXED = 2'd2,
        PM_EXT   = 2'd3
    } pitch_mode_t;

    typedef enum logic [1:0] {
        CFG_PITCH_MODE   = 2'd0,
        CFG_CV_SCALE     = 2'd1,
        CFG_COARSE_RANGE = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    localparam int unsigned CFG_W = 16;

    localparam logic [15:0] CV_SCALE_RST     = 16'd15360;
    localparam logic [15:0] COARSE_RANGE_RST = 16'd7680;

    // pitch constants in 1/128 semitone
    localparam logic signed [19:0] PITCH_C3   = 20'sd7680;  // 60 << 7
    localparam logic signed [19:0] PITCH_A440 = 20'sd8832;  // 69 << 7

    localparam logic signed [12:0] COARSE_OFFSET = 13'sd1024;
    localparam logic signed [4:0]  EXT_GAIN      = 5'sd9;

    localparam int unsigned IN_TDATA_W  = 160;
    localparam int unsigned OUT_TDATA_W = 72;

endpackage

>>> src/cv_pot_to_synth_params.sv
// ----------------------------------------------------------------------------
// CV/pot to synth parameters
// Turns one frame of CV and pot readings into pitch, fine, FM and two
// timbre parameters through a three-stage pipeline.
// ----------------------------------------------------------------------------
// While the output is not stalled, one frame enters per clock and its result
// passes stage 1, stage 2 and the output register at one per cycle. The
// depth is set by the attenuverter law: stage 1 squares the attenuverter pot,
// stage 2 multiplies the square by the CV magnitude, stage 3 shifts, restores
// the sign, adds the pot and clips into the output register. Pitch is formed
// alongside: CV and coarse products in stage 1, mode select and sum in stage 2.
// Each stage holds a valid bit, empty stages fill even while the output is
// stalled, and a stalled stage holds its contents. Configuration registers are
// written through the plain write port and must only change while no frame is
// in flight; index 3 is ignored.
`include "cv_pot_to_synth_params_defines.svh"

module cv_pot_to_synth_params (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wen,
    input  logic [1:0]                         cfg_index,
    input  logic [cvpot_pkg::CFG_W-1:0]        cfg_wdata,
    // input frame stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // low to high: voct_cv, coarse_pot, fine_pot, fm_cv, fm_amount_pot,
    // param1_pot, param1_cv, mod_amount_pot, param2_pot, param2_cv (16 each)
    input  logic [cvpot_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // low to high: pitch_out[17:0], fine_out[33:18], fm_out[45:34],
    // param1_out[57:46], param2_out[69:58], zero pad [71:70]
    output logic [cvpot_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cvpot_pkg::pitch_mode_t pitch_mode_reg;
    logic [15:0]            cv_scale_reg;
    logic [15:0]            coarse_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_mode_reg   <= cvpot_pkg::PM_TRACK;
            cv_scale_reg     <= cvpot_pkg::CV_SCALE_RST;
            coarse_range_reg <= cvpot_pkg::COARSE_RANGE_RST;
        end else if (cfg_wen) begin
            unique case (cvpot_pkg::cfg_index_t'(cfg_index))
                cvpot_pkg::CFG_PITCH_MODE:
                    pitch_mode_reg <= cvpot_pkg::pitch_mode_t'(cfg_wdata[1:0]);
                cvpot_pkg::CFG_CV_SCALE:     cv_scale_reg     <= cfg_wdata;
                cvpot_pkg::CFG_COARSE_RANGE: coarse_range_reg <= cfg_wdata;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage advances when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic out_adv, s2_adv, s1_adv;

    assign out_adv  = !out_valid_reg || m_tready;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign s_tready = s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_adv)  s1_valid_reg  <= s_tvalid;
            if (s2_adv)  s2_valid_reg  <= s1_valid_reg;
            if (out_adv) out_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack, pitch products, magnitudes and squares, param2
    // ------------------------------------------------------------------
    logic signed [15:0] voct_cv, coarse_pot, fine_pot, fm_cv, fm_amt;
    logic signed [15:0] p1_cv, mod_amt, p2_cv;
    logic        [15:0] p1_pot, p2_pot;

    assign voct_cv    = s_tdata[15:0];
    assign coarse_pot = s_tdata[31:16];
    assign fine_pot   = s_tdata[47:32];
    assign fm_cv      = s_tdata[63:48];
    assign fm_amt     = s_tdata[79:64];
    assign p1_pot     = s_tdata[95:80];
    assign p1_cv      = s_tdata[111:96];
    assign mod_amt    = s_tdata[127:112];
    assign p2_pot     = s_tdata[143:128];
    assign p2_cv      = s_tdata[159:144];

    logic signed [11:0] cv12, crs12;
    logic signed [12:0] crs_op, ext_sum;
    logic signed [28:0] cv_prod_next;
    logic signed [29:0] crs_prod_next;
    logic signed [17:0] ext_prod;
    logic signed [17:0] ext_pitch_next;
    logic signed [16:0] fm_amt_x, mod_amt_x, fm_cv_x, p1_v;
    logic        [15:0] fm_amag, mod_amag, fm_vmag;
    logic        [16:0] p1_vmag_next;
    logic        [31:0] fm_sq_full, p1_sq_full;
    logic signed [17:0] p2_sum;
    logic        [11:0] p2_out_next;

    always_comb begin
        cv12   = voct_cv[15:4];     // floor shift by 4
        crs12  = coarse_pot[15:4];
        // tracking mode offsets the coarse pot by one octave-ish constant
        crs_op = (pitch_mode_reg == cvpot_pkg::PM_TRACK)
               ? (cvpot_pkg::COARSE_OFFSET + 13'(crs12)) : 13'(crs12);
        cv_prod_next  = 29'(cv12) * $signed({1'b0, cv_scale_reg});
        crs_prod_next = 30'(crs_op) * $signed({1'b0, coarse_range_reg});
        ext_sum        = 13'(cv12) + 13'(crs12);
        ext_prod       = 18'(ext_sum) * 18'(cvpot_pkg::EXT_GAIN);
        ext_pitch_next = ext_prod >>> 1;

        fm_amt_x  = 17'(fm_amt);
        mod_amt_x = 17'(mod_amt);
        fm_cv_x   = 17'(fm_cv);
        p1_v      = {p1_cv, 1'b0};
        fm_amag   = fm_amt[15]  ? 16'(-fm_amt_x)  : fm_amt;
        mod_amag  = mod_amt[15] ? 16'(-mod_amt_x) : mod_amt;
        fm_vmag   = fm_cv[15]   ? 16'(-fm_cv_x)   : fm_cv;
        p1_vmag_next = p1_v[16] ? 17'(-p1_v) : p1_v;
        fm_sq_full = fm_amag * fm_amag;
        p1_sq_full = mod_amag * mod_amag;

        p2_sum = $signed({2'b00, p2_pot}) + $signed({p2_cv[15], p2_cv, 1'b0});
        if (p2_sum[17])
            p2_out_next = '0;
        else if (p2_sum[16])
            p2_out_next = '1;
        else
            p2_out_next = p2_sum[15:4];
    end

    logic signed [28:0] s1_cv_prod_reg;
    logic signed [29:0] s1_crs_prod_reg;
    logic signed [17:0] s1_ext_pitch_reg;
    logic        [30:0] s1_fm_sq_reg, s1_p1_sq_reg;
    logic        [15:0] s1_fm_vmag_reg;
    logic        [16:0] s1_p1_vmag_reg;
    logic               s1_fm_neg_reg, s1_p1_neg_reg;
    logic        [15:0] s1_p1_pot_reg;
    logic        [15:0] s1_fine_reg;
    logic        [11:0] s1_p2_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s1_cv_prod_reg   <= cv_prod_next;
            s1_crs_prod_reg  <= crs_prod_next;
            s1_ext_pitch_reg <= ext_pitch_next;
            s1_fm_sq_reg     <= fm_sq_full[30:0];   // at most 2^30
            s1_p1_sq_reg     <= p1_sq_full[30:0];
            s1_fm_vmag_reg   <= fm_vmag;
            s1_p1_vmag_reg   <= p1_vmag_next;
            s1_fm_neg_reg    <= fm_cv[15] ^ fm_amt[15];
            s1_p1_neg_reg    <= p1_cv[15] ^ mod_amt[15];
            s1_p1_pot_reg    <= p1_pot;
            s1_fine_reg      <= fine_pot;
            s1_p2_reg        <= p2_out_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pitch mode select, attenuverter products
    // ------------------------------------------------------------------
    logic signed [19:0] pitch_sum;
    logic signed [17:0] pitch_next;
    logic        [46:0] fm_prod_next;
    logic        [47:0] p1_prod_next;

    always_comb begin
        // upper product bits are the floor shift by 12; keep them signed
        pitch_sum = 20'($signed(s1_cv_prod_reg[28:12]))
                  + 20'($signed(s1_crs_prod_reg[29:12]));
        unique case (pitch_mode_reg)
            cvpot_pkg::PM_TRACK: pitch_next = pitch_sum[17:0];
            cvpot_pkg::PM_FREE:  pitch_next = 18'(pitch_sum + cvpot_pkg::PITCH_C3);
            cvpot_pkg::PM_FIXED: pitch_next = 18'(cvpot_pkg::PITCH_A440);
            cvpot_pkg::PM_EXT:   pitch_next = s1_ext_pitch_reg;
            default:             pitch_next = s1_ext_pitch_reg;
        endcase
        fm_prod_next = 47'(s1_fm_sq_reg) * 47'(s1_fm_vmag_reg);
        p1_prod_next = 48'(s1_p1_sq_reg) * 48'(s1_p1_vmag_reg);
    end

    logic signed [17:0] s2_pitch_reg;
    logic        [46:0] s2_fm_prod_reg;
    logic        [47:0] s2_p1_prod_reg;
    logic               s2_fm_neg_reg, s2_p1_neg_reg;
    logic        [15:0] s2_p1_pot_reg;
    logic        [15:0] s2_fine_reg;
    logic        [11:0] s2_p2_reg;

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            s2_pitch_reg   <= pitch_next;
            s2_fm_prod_reg <= fm_prod_next;
            s2_p1_prod_reg <= p1_prod_next;
            s2_fm_neg_reg  <= s1_fm_neg_reg;
            s2_p1_neg_reg  <= s1_p1_neg_reg;
            s2_p1_pot_reg  <= s1_p1_pot_reg;
            s2_fine_reg    <= s1_fine_reg;
            s2_p2_reg      <= s1_p2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: drop 30 fraction bits (truncate toward zero), restore sign,
    // clip, and load the output register
    // ------------------------------------------------------------------
    logic        [16:0] fm_mag;
    logic        [17:0] p1_mag;
    logic signed [17:0] fm_att;
    logic signed [19:0] p1_att, p1_sum;
    logic        [11:0] fm_out_next, p1_out_next;

    always_comb begin
        fm_mag = s2_fm_prod_reg[46:30];
        p1_mag = s2_p1_prod_reg[47:30];
        fm_att = s2_fm_neg_reg ? -$signed({1'b0, fm_mag}) : $signed({1'b0, fm_mag});
        p1_att = s2_p1_neg_reg ? -$signed({2'b00, p1_mag}) : $signed({2'b00, p1_mag});

        if (fm_att > 18'sd32767)
            fm_out_next = 12'h7FF;
        else if (fm_att < -18'sd32768)
            fm_out_next = 12'h800;
        else
            fm_out_next = fm_att[15:4];

        p1_sum = $signed({4'b0000, s2_p1_pot_reg}) + p1_att;
        if (p1_sum[19])
            p1_out_next = '0;
        else if (p1_sum[18:16] != 3'b000)
            p1_out_next = '1;
        else
            p1_out_next = p1_sum[15:4];
    end

    logic [cvpot_pkg::OUT_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            out_data_reg <= {2'b00, s2_p2_reg, p1_out_next, fm_out_next,
                             s2_fine_reg, s2_pitch_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an accepted transaction always lands in stage 1
    `CVP_ASSERT(a_accept_lands, aclk, aresetn, (s_tvalid && s_tready) |=> s1_valid_reg)
    // a full, stalled pipeline refuses input
    `CVP_ASSERT(a_full_stall, aclk, aresetn,
        (s1_valid_reg && s2_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
    // a stage blocked downstream keeps its product
    `CVP_ASSERT(a_s2_hold, aclk, aresetn,
        (s2_valid_reg && !out_adv) |=> (s2_valid_reg && $stable(s2_fm_prod_reg)))

endmodule
